>>> design/itrt_pkg.sv
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared widths, character codes, request structs and the digit encoder for
// the integer to radix text converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

  // Widths
  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 6;
  localparam int IDX_W       = $clog2(VALUE_WIDTH);
  localparam int STEP_W      = $clog2(VALUE_WIDTH);

  // Base limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_A     = 7'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;  // '-'
  localparam logic [CHAR_W-1:0] CH_ERR   = 7'h00;

  // One classified conversion request
  typedef struct packed {
    logic                   bad;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic [RADIX_W-1:0]     radix;
  } job_t;

  // Divider request and response
  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_rsp_t;

  // Digit value to ASCII, lower-case letters above nine
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

>>> design/itrt_front.sv
// ----------------------------------------------------------------------------
// itrt_front
// Holds the base register, classifies each incoming request (base check,
// sign, magnitude) and buffers it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module itrt_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [itrt_pkg::RADIX_W-1:0]         cfg_wdata,
  input  logic                                 in_push,
  input  logic signed [itrt_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                 in_full,
  output logic                                 job_valid,
  output itrt_pkg::job_t                       job,
  input  logic                                 job_pop
);
  import itrt_pkg::*;

  logic [RADIX_W-1:0]     radix_r;
  job_t                   q_r [2];
  logic                   wr_ptr_r;
  logic                   rd_ptr_r;
  logic [1:0]             cnt_r;
  logic                   push_ok;
  logic                   pop_ok;
  logic [VALUE_WIDTH-1:0] uval;
  job_t                   cls;

  // Base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_W'(10);
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  // Classify: base range, sign, magnitude (most negative maps to 2^(W-1))
  always_comb begin
    uval      = VALUE_WIDTH'(in_value);
    cls.bad   = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
    cls.neg   = uval[VALUE_WIDTH-1];
    cls.mag   = cls.neg ? (~uval + VALUE_WIDTH'(1)) : uval;
    cls.radix = radix_r;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = job_pop && job_valid;

  // Queue payload
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= ~wr_ptr_r;
      if (pop_ok)  rd_ptr_r <= ~rd_ptr_r;
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> design/itrt_divider.sv
// ----------------------------------------------------------------------------
// itrt_divider
// Restoring divider, one quotient bit per cycle: magnitude by base, giving
// the next quotient and the low digit.
// ----------------------------------------------------------------------------
module itrt_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  itrt_pkg::div_req_t req,
  output itrt_pkg::div_rsp_t rsp
);
  import itrt_pkg::*;

  logic [VALUE_WIDTH-1:0] quo_r;
  logic [DIGIT_W-1:0]     rem_r;
  logic [RADIX_W-1:0]     dsr_r;
  logic [STEP_W-1:0]      step_r;
  logic                   busy_r;
  logic                   done_r;
  logic [DIGIT_W:0]       trial;
  logic [DIGIT_W:0]       diff;
  logic                   fits;

  // One restoring step
  always_comb begin
    trial = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff  = trial - (DIGIT_W+1)'(dsr_r);
    fits  = (trial >= (DIGIT_W+1)'(dsr_r));
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[VALUE_WIDTH-2:0], fits};
      rem_r <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      if (step_r == STEP_W'(VALUE_WIDTH-1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

>>> design/itrt_back.sv
// ----------------------------------------------------------------------------
// itrt_back
// Sequencer: takes a classified request, peels digits low first through the
// divider into a digit store, then sends sign and digits high first through
// a one-entry output register; a request with a bad base sends one error character instead.
// ----------------------------------------------------------------------------
module itrt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  itrt_pkg::job_t                job,
  output logic                          job_pop,
  output itrt_pkg::div_req_t            dreq,
  input  itrt_pkg::div_rsp_t            drsp,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [itrt_pkg::CHAR_W-1:0]   out_char_code,
  output logic                          out_last,
  output logic                          out_bad_radix
);
  import itrt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_BAD  = 3'd4;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic               neg_r;
  logic [RADIX_W-1:0] radix_r;
  logic [IDX_W-1:0]   nd_r;
  logic [IDX_W-1:0]   idx_r;
  logic [DIGIT_W-1:0] dig_r [VALUE_WIDTH];
  logic               ov_r;
  logic [CHAR_W-1:0]  oc_r;
  logic               ol_r;
  logic               ob_r;
  logic               out_free;
  logic               more;

  assign out_free = !ov_r || out_pop;
  assign more     = (drsp.quotient != '0) && (nd_r < IDX_W'(VALUE_WIDTH-1));
  assign job_pop  = (state_r == S_IDLE) && job_valid;

  // Divider requests: first digit from the new request, later ones from quotient
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = drsp.quotient;
    dreq.divisor  = radix_r;
    if (state_r == S_IDLE) begin
      dreq.start    = job_valid && !job.bad;
      dreq.dividend = job.mag;
      dreq.divisor  = job.radix;
    end else if (state_r == S_DIV) begin
      dreq.start = drsp.done && more;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (job_valid) state_nxt = job.bad ? S_BAD : S_DIV;
      S_DIV:  if (drsp.done && !more) state_nxt = neg_r ? S_SIGN : S_EMIT;
      S_SIGN: if (out_free) state_nxt = S_EMIT;
      S_EMIT: if (out_free && idx_r == '0) state_nxt = S_IDLE;
      S_BAD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request fields, digit counters and digit store
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && job_valid) begin
      neg_r   <= job.neg;
      radix_r <= job.radix;
      nd_r    <= '0;
    end
    if (state_r == S_DIV && drsp.done) begin
      dig_r[nd_r] <= drsp.remainder;
      nd_r        <= nd_r + IDX_W'(1);
      idx_r       <= nd_r;
    end
    if (state_r == S_EMIT && out_free) begin
      idx_r <= idx_r - IDX_W'(1);
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      case (state_r)
        S_SIGN: begin
          oc_r <= CH_MINUS;
          ol_r <= 1'b0;
          ob_r <= 1'b0;
        end
        S_EMIT: begin
          oc_r <= digit_char(dig_r[idx_r]);
          ol_r <= (idx_r == '0);
          ob_r <= 1'b0;
        end
        S_BAD: begin
          oc_r <= CH_ERR;
          ol_r <= 1'b1;
          ob_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_free) begin
      ov_r <= (state_r == S_SIGN) || (state_r == S_EMIT) || (state_r == S_BAD);
    end
  end

  assign out_empty     = !ov_r;
  assign out_char_code = oc_r;
  assign out_last      = ol_r;
  assign out_bad_radix = ob_r;

endmodule

>>> design/integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text
// Converts a signed integer to ASCII text in a configurable base, one
// character per result, most significant digit first.
// ----------------------------------------------------------------------------
// Channel   Ports                                        Direction
// input     in_push, in_full, in_value                   request in
// result    out_empty, out_pop, out_char_code,
//           out_last, out_bad_radix                      character out
// config    cfg_we, cfg_wdata                            base register write
//
// Each digit costs one pass of the bit-serial divider, followed by a store into
// the digit store; an invalid base skips the divider and gives one error character.
// A two-entry request queue lets new requests in while one is converted.
// Reset (rst_n low, synchronous) empties both sides and sets the base to 10.
// Characters stall in the output register while out_pop is low.
// ----------------------------------------------------------------------------
module integer_to_radix_text (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [itrt_pkg::RADIX_W-1:0]            cfg_wdata,
  input  logic                                    in_push,
  input  logic signed [itrt_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                    in_full,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic [itrt_pkg::CHAR_W-1:0]             out_char_code,
  output logic                                    out_last,
  output logic                                    out_bad_radix
);
  import itrt_pkg::*;

  logic     job_valid;
  logic     job_pop;
  job_t     job;
  div_req_t dreq;
  div_rsp_t drsp;

  itrt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_value  (in_value),
    .in_full   (in_full),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  itrt_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  itrt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid),
    .job           (job),
    .job_pop       (job_pop),
    .dreq          (dreq),
    .drsp          (drsp),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_bad_radix (out_bad_radix)
  );

endmodule
